// File: src/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502_pkg: shared types and constants for the 6502 instruction step core
// Request kinds, status codes, flag bits, decode types and sequencer states.
// ----------------------------------------------------------------------------
package c6502_pkg;

    localparam int AddrBitsDefault = 16;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_SETPC = 2'd2,
        K_EXEC  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BRK = 2'd1,
        ST_UNK = 2'd2
    } t_status;

    localparam logic [7:0] F_C = 8'h01;
    localparam logic [7:0] F_Z = 8'h02;
    localparam logic [7:0] F_I = 8'h04;
    localparam logic [7:0] F_D = 8'h08;
    localparam logic [7:0] F_B = 8'h10;
    localparam logic [7:0] F_K = 8'h20;
    localparam logic [7:0] F_V = 8'h40;
    localparam logic [7:0] F_N = 8'h80;

    typedef enum logic [3:0] {
        M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY,
        M_IND, M_IZX, M_IZY, M_REL
    } t_mode;

    typedef enum logic [5:0] {
        O_UNK, O_BRK, O_ORA, O_AND, O_EOR, O_ADC, O_STA, O_LDA, O_CMP, O_SBC,
        O_CPX, O_CPY, O_BIT, O_DEX, O_DEY, O_INX, O_INY, O_INC, O_DEC,
        O_ASL, O_LSR, O_ROL, O_ROR, O_LDX, O_LDY, O_STX, O_STY,
        O_PHA, O_PHP, O_PLA, O_PLP, O_TAY, O_TAX, O_TSX, O_TXA, O_TXS, O_TYA,
        O_CLC, O_CLD, O_CLI, O_CLV, O_SEC, O_SED, O_SEI, O_JMP, O_JSR, O_RTS,
        O_RTI, O_BPL, O_BMI, O_BVC, O_BVS, O_BCC, O_BCS, O_BNE, O_BEQ, O_NOP
    } t_op;

    typedef struct packed {
        t_op   op;
        t_mode mode;
    } t_dec;

    typedef enum logic [4:0] {
        S_IDLE,    // wait for a request
        S_MEMRD,   // kind 1 read data returns
        S_OPC,     // opcode returns
        S_OPR1,    // first operand byte returns
        S_OPR2,    // second operand byte returns
        S_PTRLO,   // pointer low byte returns
        S_PTRHI,   // pointer high byte returns
        S_DATA,    // operand data returns
        S_WB,      // memory write of result
        S_PUSH2,   // second push of JSR
        S_POP1,    // pop results
        S_POP2,
        S_POP3,
        S_DONE     // result word waiting
    } t_state;

    function automatic t_dec decode(input logic [7:0] op);
        t_dec d;
        d.op   = O_UNK;
        d.mode = M_IMP;
        if (op[1:0] == 2'b01) begin
            if (op != 8'h89) begin
                unique case (op[7:5])
                    3'd0: d.op = O_ORA;
                    3'd1: d.op = O_AND;
                    3'd2: d.op = O_EOR;
                    3'd3: d.op = O_ADC;
                    3'd4: d.op = O_STA;
                    3'd5: d.op = O_LDA;
                    3'd6: d.op = O_CMP;
                    default: d.op = O_SBC;
                endcase
                unique case (op[4:2])
                    3'd0: d.mode = M_IZX;
                    3'd1: d.mode = M_ZP;
                    3'd2: d.mode = M_IMM;
                    3'd3: d.mode = M_ABS;
                    3'd4: d.mode = M_IZY;
                    3'd5: d.mode = M_ZPX;
                    3'd6: d.mode = M_ABY;
                    default: d.mode = M_ABX;
                endcase
            end
        end else begin
            unique case (op)
                8'h0A: d = '{O_ASL, M_ACC}; 8'h06: d = '{O_ASL, M_ZP};
                8'h16: d = '{O_ASL, M_ZPX}; 8'h0E: d = '{O_ASL, M_ABS};
                8'h1E: d = '{O_ASL, M_ABX};
                8'h2A: d = '{O_ROL, M_ACC}; 8'h26: d = '{O_ROL, M_ZP};
                8'h36: d = '{O_ROL, M_ZPX}; 8'h2E: d = '{O_ROL, M_ABS};
                8'h3E: d = '{O_ROL, M_ABX};
                8'h4A: d = '{O_LSR, M_ACC}; 8'h46: d = '{O_LSR, M_ZP};
                8'h56: d = '{O_LSR, M_ZPX}; 8'h4E: d = '{O_LSR, M_ABS};
                8'h5E: d = '{O_LSR, M_ABX};
                8'h6A: d = '{O_ROR, M_ACC}; 8'h66: d = '{O_ROR, M_ZP};
                8'h76: d = '{O_ROR, M_ZPX}; 8'h6E: d = '{O_ROR, M_ABS};
                8'h7E: d = '{O_ROR, M_ABX};
                8'hE6: d = '{O_INC, M_ZP};  8'hF6: d = '{O_INC, M_ZPX};
                8'hEE: d = '{O_INC, M_ABS}; 8'hFE: d = '{O_INC, M_ABX};
                8'hC6: d = '{O_DEC, M_ZP};  8'hD6: d = '{O_DEC, M_ZPX};
                8'hCE: d = '{O_DEC, M_ABS}; 8'hDE: d = '{O_DEC, M_ABX};
                8'hA2: d = '{O_LDX, M_IMM}; 8'hA6: d = '{O_LDX, M_ZP};
                8'hB6: d = '{O_LDX, M_ZPY}; 8'hAE: d = '{O_LDX, M_ABS};
                8'hBE: d = '{O_LDX, M_ABY};
                8'hA0: d = '{O_LDY, M_IMM}; 8'hA4: d = '{O_LDY, M_ZP};
                8'hB4: d = '{O_LDY, M_ZPX}; 8'hAC: d = '{O_LDY, M_ABS};
                8'hBC: d = '{O_LDY, M_ABX};
                8'h86: d = '{O_STX, M_ZP};  8'h96: d = '{O_STX, M_ZPY};
                8'h8E: d = '{O_STX, M_ABS};
                8'h84: d = '{O_STY, M_ZP};  8'h94: d = '{O_STY, M_ZPX};
                8'h8C: d = '{O_STY, M_ABS};
                8'hE0: d = '{O_CPX, M_IMM}; 8'hE4: d = '{O_CPX, M_ZP};
                8'hEC: d = '{O_CPX, M_ABS};
                8'hC0: d = '{O_CPY, M_IMM}; 8'hC4: d = '{O_CPY, M_ZP};
                8'hCC: d = '{O_CPY, M_ABS};
                8'h24: d = '{O_BIT, M_ZP};  8'h2C: d = '{O_BIT, M_ABS};
                8'hCA: d = '{O_DEX, M_IMP}; 8'h88: d = '{O_DEY, M_IMP};
                8'hE8: d = '{O_INX, M_IMP}; 8'hC8: d = '{O_INY, M_IMP};
                8'h48: d = '{O_PHA, M_IMP}; 8'h08: d = '{O_PHP, M_IMP};
                8'h68: d = '{O_PLA, M_IMP}; 8'h28: d = '{O_PLP, M_IMP};
                8'hA8: d = '{O_TAY, M_IMP}; 8'hAA: d = '{O_TAX, M_IMP};
                8'hBA: d = '{O_TSX, M_IMP}; 8'h8A: d = '{O_TXA, M_IMP};
                8'h9A: d = '{O_TXS, M_IMP}; 8'h98: d = '{O_TYA, M_IMP};
                8'h18: d = '{O_CLC, M_IMP}; 8'hD8: d = '{O_CLD, M_IMP};
                8'h58: d = '{O_CLI, M_IMP}; 8'hB8: d = '{O_CLV, M_IMP};
                8'h38: d = '{O_SEC, M_IMP}; 8'hF8: d = '{O_SED, M_IMP};
                8'h78: d = '{O_SEI, M_IMP};
                8'hEA: d = '{O_NOP, M_IMP}; 8'h00: d = '{O_BRK, M_IMP};
                8'h60: d = '{O_RTS, M_IMP}; 8'h40: d = '{O_RTI, M_IMP};
                8'h4C: d = '{O_JMP, M_ABS}; 8'h6C: d = '{O_JMP, M_IND};
                8'h20: d = '{O_JSR, M_ABS};
                8'h10: d = '{O_BPL, M_REL}; 8'h30: d = '{O_BMI, M_REL};
                8'h50: d = '{O_BVC, M_REL}; 8'h70: d = '{O_BVS, M_REL};
                8'h90: d = '{O_BCC, M_REL}; 8'hB0: d = '{O_BCS, M_REL};
                8'hD0: d = '{O_BNE, M_REL}; 8'hF0: d = '{O_BEQ, M_REL};
                default: d = '{O_UNK, M_IMP};
            endcase
        end
        return d;
    endfunction

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        return (p & ~(F_N | F_Z)) | ((v == 8'h00) ? F_Z : 8'h00) | (v & F_N);
    endfunction

endpackage

// File: src/c6502_if.sv
// ----------------------------------------------------------------------------
// c6502_req_if / c6502_rsp_if: valid/ready channels of the step core
// One word moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface c6502_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, kind, address, write_data, input ready);
    modport sink   (input valid, kind, address, write_data, output ready);
endinterface

interface c6502_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  step_status;
    logic [15:0] instr_address;
    logic [7:0]  opcode;
    logic [7:0]  acc_before;
    logic [7:0]  xreg_before;
    logic [7:0]  yreg_before;
    logic [7:0]  flags_before;
    logic [7:0]  sp_before;
    logic [15:0] next_pc;
    logic [7:0]  read_data;

    modport source (output valid, step_status, instr_address, opcode, acc_before,
                    xreg_before, yreg_before, flags_before, sp_before, next_pc,
                    read_data, input ready);
    modport sink   (input valid, step_status, instr_address, opcode, acc_before,
                    xreg_before, yreg_before, flags_before, sp_before, next_pc,
                    read_data, output ready);
endinterface

// File: src/c6502_mem.sv
// ----------------------------------------------------------------------------
// c6502_mem: flat byte memory
// Single port, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module c6502_mem #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [7:0]           i_wdata,
    output logic [7:0]           o_rdata
);
    logic [7:0] r_mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: src/cpu_6502_instruction_step.sv
// Memory use: the single byte-memory port takes one access per cycle (opcode,
//   operands, pointer, data, write-back, stack); every request ends with its
//   result word held in the result register.
// Throughput: one request at a time; next request is taken once the result
//   word has left.
// Reset: registers A X Y S PC cleared, P = 0x20; memory is not cleared.
// ----------------------------------------------------------------------------
// cpu_6502_instruction_step: 6502 core stepping one request per word
// Sequencer around a byte memory: fetch, address, execute, write back.
// ----------------------------------------------------------------------------
module cpu_6502_instruction_step #(
    parameter int ADDR_BITS = c6502_pkg::AddrBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c6502_req_if.sink   req,
    c6502_rsp_if.source rsp
);
    import c6502_pkg::*;

    // architectural registers
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_s, n_s, r_p, n_p;
    // request and working registers
    t_state      r_st, n_st;
    t_state      n_st_x;
    logic [1:0]  r_kind;
    logic [15:0] r_addr, n_addr;     // request address, later effective address
    logic [7:0]  r_wdata;
    logic [7:0]  r_opc, n_opc;
    t_dec        r_dec, n_dec;
    logic [7:0]  r_lo, n_lo;         // first operand / pointer low
    logic [15:0] r_ptr, n_ptr;       // pointer for indirect modes
    logic [7:0]  r_tmp, n_tmp;       // pulled status for RTI, write-back byte
    // result word
    logic [1:0]  r_stat, n_stat;
    logic [15:0] r_iaddr, n_iaddr;
    logic [7:0]  r_rdata, n_rdata;
    logic [7:0]  r_ba, r_bx, r_by, r_bp, r_bs;

    // memory port
    logic                 mem_we;
    logic [15:0]          mem_addr;
    logic [7:0]           mem_wdata, mem_rdata;

    c6502_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr[ADDR_BITS-1:0]),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    logic accept;
    assign req.ready = (r_st == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid         = (r_st == S_DONE);
    assign rsp.step_status   = r_stat;
    assign rsp.instr_address = r_iaddr;
    assign rsp.opcode        = r_opc;
    assign rsp.acc_before    = r_ba;
    assign rsp.xreg_before   = r_bx;
    assign rsp.yreg_before   = r_by;
    assign rsp.flags_before  = r_bp;
    assign rsp.sp_before     = r_bs;
    assign rsp.next_pc       = r_pc;
    assign rsp.read_data     = r_rdata;

    // helpers for the data stage
    logic [7:0]  m;
    logic [8:0]  sum;
    logic [7:0]  addend, res8, cmp_reg;
    logic [8:0]  cmp_diff;
    logic [15:0] base16;
    logic [7:0]  ix;

    always_comb begin
        m        = mem_rdata;
        addend   = (r_dec.op == O_SBC) ? ~m : m;
        sum      = {1'b0, r_a} + {1'b0, addend} + {8'h00, r_p[0]};
        cmp_reg  = (r_dec.op == O_CPX) ? r_x : ((r_dec.op == O_CPY) ? r_y : r_a);
        cmp_diff = {1'b0, cmp_reg} - {1'b0, m};
        base16   = {m, r_lo};
        ix       = (r_dec.mode == M_ABY || r_dec.mode == M_ZPY || r_dec.mode == M_IZY)
                   ? r_y : r_x;
        res8     = 8'h00;
        case (r_dec.op)
            O_ASL: res8 = {m[6:0], 1'b0};
            O_ROL: res8 = {m[6:0], r_p[0]};
            O_LSR: res8 = {1'b0, m[7:1]};
            O_ROR: res8 = {r_p[0], m[7:1]};
            O_INC: res8 = m + 8'd1;
            O_DEC: res8 = m - 8'd1;
            default: res8 = m;
        endcase
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(req.kind))
                        K_READ:  n_st = S_MEMRD;
                        K_EXEC:  n_st = S_OPC;
                        default: n_st = S_DONE;
                    endcase
                end
            end
            S_MEMRD: n_st = S_DONE;
            S_DONE:  if (rsp.ready) n_st = S_IDLE;
            default: n_st = r_st;   // datapath block below sets sequencing
        endcase
        if (r_st != S_IDLE && r_st != S_MEMRD && r_st != S_DONE) begin
            n_st = n_st_x;
        end
    end

    // datapath, memory port and sequencing of execute states
    always_comb begin
        n_st_x  = S_DONE;
        n_pc = r_pc; n_a = r_a; n_x = r_x; n_y = r_y; n_s = r_s; n_p = r_p;
        n_addr = r_addr; n_opc = r_opc; n_dec = r_dec; n_lo = r_lo; n_ptr = r_ptr;
        n_tmp = r_tmp; n_stat = r_stat; n_iaddr = r_iaddr; n_rdata = r_rdata;
        mem_we = 1'b0; mem_addr = r_addr; mem_wdata = r_wdata;
        unique case (r_st)
            S_IDLE: begin
                mem_addr = req.address;
                if (accept) begin
                    n_stat = ST_OK; n_iaddr = 16'h0000; n_opc = 8'h00; n_rdata = 8'h00;
                    unique case (t_kind'(req.kind))
                        K_WRITE: begin
                            mem_we = 1'b1; mem_wdata = req.write_data;
                        end
                        K_READ:  ;
                        K_SETPC: n_pc = req.address;
                        K_EXEC: begin
                            mem_addr = r_pc; n_iaddr = r_pc; n_pc = r_pc + 16'd1;
                        end
                        default: ;
                    endcase
                end
            end
            S_MEMRD: n_rdata = mem_rdata;
            S_OPC: begin
                n_opc = mem_rdata;
                n_dec = decode(mem_rdata);
                mem_addr = r_pc;
                n_st_x = S_OPR1;
                if (n_dec.op == O_UNK) begin
                    n_stat = ST_UNK; n_st_x = S_DONE;
                end else if (n_dec.op == O_BRK) begin
                    n_stat = ST_BRK; n_st_x = S_DONE;
                end else begin
                    case (n_dec.mode)
                        M_IMP, M_ACC: begin
                            n_st_x = S_DONE;
                            case (n_dec.op)
                                O_ASL: begin n_a = {r_a[6:0], 1'b0};
                                    n_p = set_nz((r_p & ~F_C) | {7'd0, r_a[7]}, n_a); end
                                O_ROL: begin n_a = {r_a[6:0], r_p[0]};
                                    n_p = set_nz((r_p & ~F_C) | {7'd0, r_a[7]}, n_a); end
                                O_LSR: begin n_a = {1'b0, r_a[7:1]};
                                    n_p = set_nz((r_p & ~F_C) | {7'd0, r_a[0]}, n_a); end
                                O_ROR: begin n_a = {r_p[0], r_a[7:1]};
                                    n_p = set_nz((r_p & ~F_C) | {7'd0, r_a[0]}, n_a); end
                                O_DEX: begin n_x = r_x - 8'd1; n_p = set_nz(r_p, n_x); end
                                O_DEY: begin n_y = r_y - 8'd1; n_p = set_nz(r_p, n_y); end
                                O_INX: begin n_x = r_x + 8'd1; n_p = set_nz(r_p, n_x); end
                                O_INY: begin n_y = r_y + 8'd1; n_p = set_nz(r_p, n_y); end
                                O_TAY: begin n_y = r_a; n_p = set_nz(r_p, r_a); end
                                O_TAX: begin n_x = r_a; n_p = set_nz(r_p, r_a); end
                                O_TSX: begin n_x = r_s; n_p = set_nz(r_p, r_s); end
                                O_TXA: begin n_a = r_x; n_p = set_nz(r_p, r_x); end
                                O_TYA: begin n_a = r_y; n_p = set_nz(r_p, r_y); end
                                O_TXS: n_s = r_x;
                                O_CLC: n_p = r_p & ~F_C;
                                O_CLD: n_p = r_p & ~F_D;
                                O_CLI: n_p = r_p & ~F_I;
                                O_CLV: n_p = r_p & ~F_V;
                                O_SEC: n_p = r_p | F_C;
                                O_SED: n_p = r_p | F_D;
                                O_SEI: n_p = r_p | F_I;
                                O_PHA: begin
                                    mem_we = 1'b1; mem_addr = {8'h01, r_s};
                                    mem_wdata = r_a; n_s = r_s - 8'd1;
                                end
                                O_PHP: begin
                                    mem_we = 1'b1; mem_addr = {8'h01, r_s};
                                    mem_wdata = r_p | F_B; n_s = r_s - 8'd1;
                                end
                                O_PLA, O_PLP, O_RTS, O_RTI: begin
                                    mem_addr = {8'h01, r_s + 8'd1}; n_s = r_s + 8'd1;
                                    n_st_x = S_POP1;
                                end
                                default: ;
                            endcase
                        end
                        M_IMM: begin
                            n_addr = r_pc; n_pc = r_pc + 16'd1; n_st_x = S_DATA;
                        end
                        default: begin
                            n_pc = r_pc + 16'd1; n_st_x = S_OPR1;
                        end
                    endcase
                end
            end
            S_OPR1: begin
                n_lo = mem_rdata;
                n_st_x = S_DATA;
                case (r_dec.mode)
                    M_ZP:  n_addr = {8'h00, mem_rdata};
                    M_ZPX, M_ZPY: n_addr = {8'h00, mem_rdata + ix};
                    M_REL: begin
                        n_addr = r_pc + {{8{mem_rdata[7]}}, mem_rdata};
                        n_st_x = S_DONE;
                        case (r_dec.op)
                            O_BPL: if (!r_p[7]) n_pc = n_addr;
                            O_BMI: if (r_p[7])  n_pc = n_addr;
                            O_BVC: if (!r_p[6]) n_pc = n_addr;
                            O_BVS: if (r_p[6])  n_pc = n_addr;
                            O_BCC: if (!r_p[0]) n_pc = n_addr;
                            O_BCS: if (r_p[0])  n_pc = n_addr;
                            O_BNE: if (!r_p[1]) n_pc = n_addr;
                            O_BEQ: if (r_p[1])  n_pc = n_addr;
                            default: ;
                        endcase
                    end
                    M_IZX: begin
                        n_ptr = {8'h00, mem_rdata + r_x};
                        mem_addr = n_ptr; n_st_x = S_PTRLO;
                    end
                    M_IZY: begin
                        n_ptr = {8'h00, mem_rdata};
                        mem_addr = n_ptr; n_st_x = S_PTRLO;
                    end
                    default: begin
                        mem_addr = r_pc; n_pc = r_pc + 16'd1; n_st_x = S_OPR2;
                    end
                endcase
                if (n_st_x == S_DATA) mem_addr = n_addr;
                if (n_st_x == S_DATA && (r_dec.op == O_STA || r_dec.op == O_STX ||
                                          r_dec.op == O_STY)) begin
                    n_st_x = S_WB;
                end
            end
            S_OPR2: begin
                n_st_x = S_DATA;
                case (r_dec.mode)
                    M_ABX, M_ABY: n_addr = base16 + {8'h00, ix};
                    M_IND: begin
                        n_ptr = base16; mem_addr = base16; n_st_x = S_PTRLO;
                    end
                    default: n_addr = base16;
                endcase
                if (r_dec.op == O_JMP && r_dec.mode == M_ABS) begin
                    n_pc = base16; n_st_x = S_DONE;
                end else if (r_dec.op == O_JSR) begin
                    mem_we = 1'b1; mem_addr = {8'h01, r_s};
                    mem_wdata = r_pc[15:8] - {7'd0, (r_pc[7:0] == 8'h00)};
                    n_s = r_s - 8'd1; n_addr = base16; n_st_x = S_PUSH2;
                end else if (n_st_x == S_DATA) begin
                    mem_addr = n_addr;
                    if (r_dec.op == O_STA || r_dec.op == O_STX || r_dec.op == O_STY)
                        n_st_x = S_WB;
                end
            end
            S_PUSH2: begin
                mem_we = 1'b1; mem_addr = {8'h01, r_s}; mem_wdata = r_pc[7:0] - 8'd1;
                n_s = r_s - 8'd1; n_pc = r_addr; n_st_x = S_DONE;
            end
            S_PTRLO: begin
                n_lo = mem_rdata;
                mem_addr = (r_dec.mode == M_IND) ? {r_ptr[15:8], r_ptr[7:0] + 8'd1}
                                                 : {8'h00, r_ptr[7:0] + 8'd1};
                n_st_x = S_PTRHI;
            end
            S_PTRHI: begin
                n_addr = (r_dec.mode == M_IZY) ? base16 + {8'h00, r_y} : base16;
                mem_addr = n_addr;
                if (r_dec.op == O_JMP) begin
                    n_pc = base16; n_st_x = S_DONE;
                end else if (r_dec.op == O_STA) begin
                    n_st_x = S_WB;
                end else begin
                    n_st_x = S_DATA;
                end
            end
            S_DATA: begin
                n_st_x = S_DONE;
                case (r_dec.op)
                    O_ORA: begin n_a = r_a | m; n_p = set_nz(r_p, n_a); end
                    O_AND: begin n_a = r_a & m; n_p = set_nz(r_p, n_a); end
                    O_EOR: begin n_a = r_a ^ m; n_p = set_nz(r_p, n_a); end
                    O_ADC, O_SBC: begin
                        n_a = sum[7:0];
                        n_p = (r_p & ~(F_C | F_V)) | {7'd0, sum[8]} |
                              ((((r_a ^ sum[7:0]) & (addend ^ sum[7:0]) & F_N) != 8'h00)
                               ? F_V : 8'h00);
                        n_p = set_nz(n_p, n_a);
                    end
                    O_CMP, O_CPX, O_CPY:
                        n_p = set_nz((r_p & ~F_C) | {7'd0, ~cmp_diff[8]}, cmp_diff[7:0]);
                    O_BIT:
                        n_p = (r_p & ~(F_N | F_V | F_Z)) | (m & (F_N | F_V)) |
                              (((r_a & m) == 8'h00) ? F_Z : 8'h00);
                    O_LDA: begin n_a = m; n_p = set_nz(r_p, m); end
                    O_LDX: begin n_x = m; n_p = set_nz(r_p, m); end
                    O_LDY: begin n_y = m; n_p = set_nz(r_p, m); end
                    O_ASL, O_ROL: begin
                        n_tmp = res8; n_st_x = S_WB;
                        n_p = set_nz((r_p & ~F_C) | {7'd0, m[7]}, res8);
                    end
                    O_LSR, O_ROR: begin
                        n_tmp = res8; n_st_x = S_WB;
                        n_p = set_nz((r_p & ~F_C) | {7'd0, m[0]}, res8);
                    end
                    O_INC, O_DEC: begin
                        n_tmp = res8; n_st_x = S_WB; n_p = set_nz(r_p, res8);
                    end
                    default: ;
                endcase
            end
            S_WB: begin
                mem_we = 1'b1;
                case (r_dec.op)
                    O_STA: mem_wdata = r_a;
                    O_STX: mem_wdata = r_x;
                    O_STY: mem_wdata = r_y;
                    default: mem_wdata = r_tmp;
                endcase
                n_st_x = S_DONE;
            end
            S_POP1: begin
                n_st_x = S_DONE;
                case (r_dec.op)
                    O_PLA: begin n_a = mem_rdata; n_p = set_nz(r_p, mem_rdata); end
                    O_PLP: n_p = (mem_rdata & ~F_B) | F_K;
                    O_RTS: begin
                        n_lo = mem_rdata; mem_addr = {8'h01, r_s + 8'd1};
                        n_s = r_s + 8'd1; n_st_x = S_POP2;
                    end
                    default: begin
                        n_tmp = mem_rdata; mem_addr = {8'h01, r_s + 8'd1};
                        n_s = r_s + 8'd1; n_st_x = S_POP2;
                    end
                endcase
            end
            S_POP2: begin
                if (r_dec.op == O_RTS) begin
                    n_pc = base16 + 16'd1; n_st_x = S_DONE;
                end else begin
                    n_lo = mem_rdata; mem_addr = {8'h01, r_s + 8'd1};
                    n_s = r_s + 8'd1; n_st_x = S_POP3;
                end
            end
            S_POP3: begin
                n_p = (r_tmp & ~F_B) | F_K; n_pc = base16; n_st_x = S_DONE;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_pc <= 16'h0000; r_a <= 8'h00; r_x <= 8'h00; r_y <= 8'h00;
            r_s <= 8'h00; r_p <= F_K;
        end else begin
            r_st <= n_st;
            r_pc <= n_pc; r_a <= n_a; r_x <= n_x; r_y <= n_y; r_s <= n_s; r_p <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= req.kind; r_wdata <= req.write_data;
            r_ba <= r_a; r_bx <= r_x; r_by <= r_y; r_bp <= r_p; r_bs <= r_s;
        end
        r_addr <= (accept) ? req.address : n_addr;
        r_opc <= n_opc; r_dec <= n_dec; r_lo <= n_lo; r_ptr <= n_ptr; r_tmp <= n_tmp;
        r_stat <= n_stat; r_iaddr <= n_iaddr; r_rdata <= n_rdata;
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.ready && rsp.valid)) else $error("ready and valid overlap");
    a_k_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p[5]) else $error("constant flag bit lost");
    a_nonexec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && r_kind != K_EXEC |-> r_stat == ST_OK && r_iaddr == 16'h0000)
        else $error("non-execute word carries trace");
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && r_kind != K_READ |-> r_rdata == 8'h00)
        else $error("read data on non-read word");
`endif
endmodule
